FILE: hw/rtl/fvd_pkg.sv
// ----------------------------------------------------------------------------
// fvd_pkg: shared definitions for the face vertex dedup block
// Field widths, register indexes, error codes and the structs that pass
// between the check, table and top-level logic.
// ----------------------------------------------------------------------------
package fvd_pkg;

  localparam int MAX_MESH_VERTS = 4096;
  localparam int REF_BITS       = 20;

  localparam int REF_W     = 21;
  localparam int IDX_W     = 20;
  localparam int KEY_W     = 3 * IDX_W;
  localparam int MESH_W    = 12;
  localparam int CNT_W     = 21;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITION_COUNT = 2'd0,
    CFG_NORMAL_COUNT   = 2'd1,
    CFG_TEXCOORD_COUNT = 2'd2,
    CFG_DEDUP_DISABLE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_POS_UNDER  = 3'd1,
    ERR_NRM_UNDER  = 3'd2,
    ERR_TEX_UNDER  = 3'd3,
    ERR_POS_OVER   = 3'd4,
    ERR_NRM_OVER   = 3'd5,
    ERR_TEX_OVER   = 3'd6,
    ERR_TABLE_FULL = 3'd7
  } err_code_t;

  typedef struct packed {
    err_code_t        err;
    logic [IDX_W-1:0] position_index;
    logic [IDX_W-1:0] texcoord_index;
    logic [IDX_W-1:0] normal_index;
  } chk_t;

  typedef struct packed {
    logic             start;
    logic             clear;
    logic             ack;
    logic             dedup_disable;
    logic [KEY_W-1:0] key;
  } tbl_req_t;

  typedef struct packed {
    logic              done;
    logic [MESH_W-1:0] mesh_index;
    logic              is_new;
    logic              full;
  } tbl_rsp_t;

endpackage

FILE: hw/rtl/fvd_if.sv
// ----------------------------------------------------------------------------
// fvd_if: valid/ready channels of the face vertex dedup block
// Input channel carries one face corner or a group start; output channel
// carries one result per face corner.
// ----------------------------------------------------------------------------
interface fvd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic signed [fvd_pkg::REF_W-1:0] position_ref;
  logic signed [fvd_pkg::REF_W-1:0] texcoord_ref;
  logic signed [fvd_pkg::REF_W-1:0] normal_ref;

  modport source (output valid, mode, position_ref, texcoord_ref, normal_ref,
                  input ready);
  modport sink (input valid, mode, position_ref, texcoord_ref, normal_ref,
                output ready);
endinterface

interface fvd_out_if;
  logic                        valid;
  logic                        ready;
  logic [fvd_pkg::MESH_W-1:0]  mesh_index;
  logic                        is_new;
  logic [fvd_pkg::IDX_W-1:0]   position_index;
  logic [fvd_pkg::IDX_W-1:0]   texcoord_index;
  logic [fvd_pkg::IDX_W-1:0]   normal_index;
  logic [2:0]                  error_code;

  modport source (output valid, mesh_index, is_new, position_index, texcoord_index,
                  normal_index, error_code, input ready);
  modport sink (input valid, mesh_index, is_new, position_index, texcoord_index,
                normal_index, error_code, output ready);
endinterface

FILE: hw/rtl/fvd_check.sv
// ----------------------------------------------------------------------------
// fvd_check: reference conversion and range check
// Turns the one-based references into zero-based indices and picks the first
// failing check: underflows (position, normal, texture), then overflows.
// ----------------------------------------------------------------------------
module fvd_check (
  input  logic signed [fvd_pkg::REF_W-1:0] position_ref,
  input  logic signed [fvd_pkg::REF_W-1:0] texcoord_ref,
  input  logic signed [fvd_pkg::REF_W-1:0] normal_ref,
  input  logic [fvd_pkg::CNT_W-1:0]        position_count,
  input  logic [fvd_pkg::CNT_W-1:0]        normal_count,
  input  logic [fvd_pkg::CNT_W-1:0]        texcoord_count,
  output fvd_pkg::chk_t                    chk
);

  localparam logic [fvd_pkg::REF_W:0] REF_LIMIT = (fvd_pkg::REF_W + 1)'(1) << fvd_pkg::REF_BITS;

  logic [fvd_pkg::REF_W-1:0] pos_m1;
  logic [fvd_pkg::REF_W-1:0] tex_m1;
  logic [fvd_pkg::REF_W-1:0] nrm_m1;
  logic pos_under, tex_under, nrm_under;
  logic pos_over, tex_over, nrm_over;

  assign pos_m1 = $unsigned(position_ref) - fvd_pkg::REF_W'(1);
  assign tex_m1 = $unsigned(texcoord_ref) - fvd_pkg::REF_W'(1);
  assign nrm_m1 = $unsigned(normal_ref) - fvd_pkg::REF_W'(1);

  // a reference of zero or below has no zero-based index
  assign pos_under = position_ref[fvd_pkg::REF_W-1] || (position_ref == '0);
  assign tex_under = texcoord_ref[fvd_pkg::REF_W-1] || (texcoord_ref == '0);
  assign nrm_under = normal_ref[fvd_pkg::REF_W-1] || (normal_ref == '0);

  assign pos_over = (pos_m1 >= position_count) || ({1'b0, pos_m1} >= REF_LIMIT);
  assign tex_over = (tex_m1 >= texcoord_count) || ({1'b0, tex_m1} >= REF_LIMIT);
  assign nrm_over = (nrm_m1 >= normal_count) || ({1'b0, nrm_m1} >= REF_LIMIT);

  always_comb begin
    if (pos_under) begin
      chk.err = fvd_pkg::ERR_POS_UNDER;
    end else if (nrm_under) begin
      chk.err = fvd_pkg::ERR_NRM_UNDER;
    end else if (tex_under) begin
      chk.err = fvd_pkg::ERR_TEX_UNDER;
    end else if (pos_over) begin
      chk.err = fvd_pkg::ERR_POS_OVER;
    end else if (nrm_over) begin
      chk.err = fvd_pkg::ERR_NRM_OVER;
    end else if (tex_over) begin
      chk.err = fvd_pkg::ERR_TEX_OVER;
    end else begin
      chk.err = fvd_pkg::ERR_NONE;
    end
    chk.position_index = pos_m1[fvd_pkg::IDX_W-1:0];
    chk.texcoord_index = tex_m1[fvd_pkg::IDX_W-1:0];
    chk.normal_index   = nrm_m1[fvd_pkg::IDX_W-1:0];
  end

endmodule

FILE: hw/rtl/fvd_table.sv
// ----------------------------------------------------------------------------
// fvd_table: triple table with linear search
// Holds the triples of the current group in a key memory, one word per mesh
// vertex with a valid flag. A small sequencer walks the memory from entry 0,
// one entry at a time with a read then a compare, and appends on a miss while there is room.
// ----------------------------------------------------------------------------
module fvd_table #(
  parameter int MAX_MESH_VERTS = fvd_pkg::MAX_MESH_VERTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fvd_pkg::tbl_req_t req,
  output fvd_pkg::tbl_rsp_t rsp
);

  localparam int AW = $clog2(MAX_MESH_VERTS);
  localparam int CW = $clog2(MAX_MESH_VERTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_MESH_VERTS);

  typedef enum logic [4:0] {
    TB_IDLE   = 5'b00001,
    TB_READ   = 5'b00010,
    TB_CMP    = 5'b00100,
    TB_INSERT = 5'b01000,
    TB_DONE   = 5'b10000
  } tb_state_t;

  tb_state_t state_r, state_nxt;
  logic [AW-1:0] scan_k_r, scan_k_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [fvd_pkg::KEY_W-1:0]  key_r;
  logic                       dis_r;
  logic [fvd_pkg::MESH_W-1:0] res_idx_r, res_idx_nxt;
  logic                       res_new_r, res_new_nxt;
  logic                       res_full_r, res_full_nxt;

  // top bit of each word marks a stored triple
  logic [fvd_pkg::KEY_W:0] key_mem [MAX_MESH_VERTS];
  logic [fvd_pkg::KEY_W:0] rd_data_r;
  logic                    mem_we;
  logic [31:0]             k_scan_wide;
  logic [31:0]             k_cnt_wide;

  assign k_scan_wide = 32'(scan_k_r);
  assign k_cnt_wide  = 32'(count_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[count_r[AW-1:0]] <= {~dis_r, key_r};
    end
    rd_data_r <= key_mem[scan_k_r];
  end

  always_comb begin
    state_nxt    = state_r;
    scan_k_nxt   = scan_k_r;
    count_nxt    = count_r;
    res_idx_nxt  = res_idx_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    mem_we       = 1'b0;
    case (state_r)
      TB_IDLE: begin
        if (req.clear) begin
          count_nxt = '0;
        end else if (req.start) begin
          scan_k_nxt = '0;
          if (req.dedup_disable || (count_r == '0)) begin
            state_nxt = TB_INSERT;
          end else begin
            state_nxt = TB_READ;
          end
        end
      end
      TB_READ: begin
        state_nxt = TB_CMP;
      end
      TB_CMP: begin
        if (rd_data_r[fvd_pkg::KEY_W] && (rd_data_r[fvd_pkg::KEY_W-1:0] == key_r)) begin
          res_idx_nxt  = k_scan_wide[fvd_pkg::MESH_W-1:0];
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt    = TB_DONE;
        end else if ((CW'(scan_k_r) + CW'(1)) == count_r) begin
          state_nxt = TB_INSERT;
        end else begin
          scan_k_nxt = scan_k_r + AW'(1);
          state_nxt  = TB_READ;
        end
      end
      TB_INSERT: begin
        if (count_r == CNT_MAX) begin
          res_idx_nxt  = '0;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b1;
        end else begin
          mem_we       = 1'b1;
          res_idx_nxt  = k_cnt_wide[fvd_pkg::MESH_W-1:0];
          res_new_nxt  = 1'b1;
          res_full_nxt = 1'b0;
          count_nxt    = count_r + CW'(1);
        end
        state_nxt = TB_DONE;
      end
      TB_DONE: begin
        // hold the result until the top level takes it
        if (req.ack) begin
          state_nxt = TB_IDLE;
        end
      end
      default: begin
        state_nxt = TB_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= TB_IDLE;
      scan_k_r <= '0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      scan_k_r <= scan_k_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == TB_IDLE) && req.start) begin
      key_r <= req.key;
      dis_r <= req.dedup_disable;
    end
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
  end

  assign rsp.done       = (state_r == TB_DONE);
  assign rsp.mesh_index = res_idx_r;
  assign rsp.is_new     = res_new_r;
  assign rsp.full       = res_full_r;

endmodule

FILE: hw/rtl/face_vertex_dedup.sv
// ----------------------------------------------------------------------------
// face_vertex_dedup: vertex deduplication for an indexed mesh
// A group start gives no result. A face corner that fails a check skips the table;
// otherwise the key memory, one read port, is searched linearly over the stored
// entries (none with dedup disabled). The input is not ready again until the
// corner's result has been pushed.
// Reset zeroes the configuration, the state and the vertex count; the key memory is not cleared.
// ----------------------------------------------------------------------------
module face_vertex_dedup #(
  parameter int MAX_MESH_VERTS = fvd_pkg::MAX_MESH_VERTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fvd_in_if.sink                        in_chan,
  fvd_out_if.source                     out_chan,
  input  logic                          cfg_wr_en,
  input  logic [fvd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fvd_pkg::CNT_W-1:0]     cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_TABLE = 4'b0100,
    ST_ERR   = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [fvd_pkg::CNT_W-1:0] position_count_r;
  logic [fvd_pkg::CNT_W-1:0] normal_count_r;
  logic [fvd_pkg::CNT_W-1:0] texcoord_count_r;
  logic                      dedup_disable_r;

  logic signed [fvd_pkg::REF_W-1:0] position_ref_r;
  logic signed [fvd_pkg::REF_W-1:0] texcoord_ref_r;
  logic signed [fvd_pkg::REF_W-1:0] normal_ref_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [fvd_pkg::MESH_W-1:0] out_mesh_r;
  logic                       out_new_r;
  logic [fvd_pkg::IDX_W-1:0]  out_pos_r;
  logic [fvd_pkg::IDX_W-1:0]  out_tex_r;
  logic [fvd_pkg::IDX_W-1:0]  out_nrm_r;
  fvd_pkg::err_code_t         out_err_r;

  fvd_pkg::chk_t     chk;
  fvd_pkg::tbl_req_t req;
  fvd_pkg::tbl_rsp_t rsp;

  logic in_acc;
  logic out_free;
  logic push;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_count_r <= '0;
      normal_count_r   <= '0;
      texcoord_count_r <= '0;
      dedup_disable_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (fvd_pkg::cfg_reg_t'(cfg_index))
        fvd_pkg::CFG_POSITION_COUNT: position_count_r <= cfg_wr_data;
        fvd_pkg::CFG_NORMAL_COUNT:   normal_count_r   <= cfg_wr_data;
        fvd_pkg::CFG_TEXCOORD_COUNT: texcoord_count_r <= cfg_wr_data;
        fvd_pkg::CFG_DEDUP_DISABLE:  dedup_disable_r  <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      position_ref_r <= in_chan.position_ref;
      texcoord_ref_r <= in_chan.texcoord_ref;
      normal_ref_r   <= in_chan.normal_ref;
    end
  end

  fvd_check u_check (
    .position_ref   (position_ref_r),
    .texcoord_ref   (texcoord_ref_r),
    .normal_ref     (normal_ref_r),
    .position_count (position_count_r),
    .normal_count   (normal_count_r),
    .texcoord_count (texcoord_count_r),
    .chk            (chk)
  );

  assign req.clear         = in_acc && in_chan.mode;
  assign req.start         = (state_r == ST_CHECK) && (chk.err == fvd_pkg::ERR_NONE);
  assign req.ack           = (state_r == ST_TABLE) && rsp.done && out_free;
  assign req.dedup_disable = dedup_disable_r;
  assign req.key           = {chk.normal_index, chk.texcoord_index, chk.position_index};

  fvd_table #(
    .MAX_MESH_VERTS (MAX_MESH_VERTS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign push = ((state_r == ST_TABLE) && rsp.done && out_free)
             || ((state_r == ST_ERR) && out_free);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !in_chan.mode) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk.err != fvd_pkg::ERR_NONE) begin
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_TABLE;
        end
      end
      ST_TABLE: begin
        if (rsp.done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the output register; errors carry zero payload
  always_ff @(posedge clk) begin
    if (push) begin
      if ((state_r == ST_ERR) || rsp.full) begin
        out_mesh_r <= '0;
        out_new_r  <= 1'b0;
        out_pos_r  <= '0;
        out_tex_r  <= '0;
        out_nrm_r  <= '0;
        out_err_r  <= (state_r == ST_ERR) ? chk.err : fvd_pkg::ERR_TABLE_FULL;
      end else begin
        out_mesh_r <= rsp.mesh_index;
        out_new_r  <= rsp.is_new;
        out_pos_r  <= chk.position_index;
        out_tex_r  <= chk.texcoord_index;
        out_nrm_r  <= chk.normal_index;
        out_err_r  <= fvd_pkg::ERR_NONE;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.mesh_index     = out_mesh_r;
  assign out_chan.is_new         = out_new_r;
  assign out_chan.position_index = out_pos_r;
  assign out_chan.texcoord_index = out_tex_r;
  assign out_chan.normal_index   = out_nrm_r;
  assign out_chan.error_code     = out_err_r;

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the face vertex dedup block
// Feeds face corners and group starts through the input channel, predicts each
// result with a behavioural copy of the dedup table and compares every result
// transaction field by field. Covers the error priority chain, hits and misses,
// dedup disabled and back-pressure from a long receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fvd_pkg::*;

  typedef struct {
    logic                    mode;
    logic signed [REF_W-1:0] pos;
    logic signed [REF_W-1:0] tex;
    logic signed [REF_W-1:0] nrm;
  } corner_t;

  typedef struct packed {
    logic [MESH_W-1:0] mesh_index;
    logic              is_new;
    logic [IDX_W-1:0]  position_index;
    logic [IDX_W-1:0]  texcoord_index;
    logic [IDX_W-1:0]  normal_index;
    err_code_t         err;
  } vert_ref_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_wr_data;

  fvd_in_if  in_chan ();
  fvd_out_if out_chan ();

  face_vertex_dedup u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted table state and register copies
  logic [KEY_W-1:0]   key_mem [MAX_MESH_VERTS];
  bit                 key_ok  [MAX_MESH_VERTS];
  int unsigned        vert_cnt;
  bit [CNT_W-1:0]     pos_lim, nrm_lim, tex_lim;
  bit                 dedup_off;

  corner_t            corner_feed [$];
  vert_ref_t          mesh_refs_due [$];
  corner_t            cur_corner;
  logic signed [REF_W-1:0] ref_pool [3][8];

  bit                 calm;
  bit                 hold_off_req;
  int                 feed_gap;
  int                 drain_gap;
  int                 fails;
  int unsigned        n_queued;
  int unsigned        n_accepted, n_results, n_hits, n_new, n_err, n_full;

  // Work out the result of one accepted transaction and queue it
  task automatic dedup_corner(input corner_t c);
    vert_ref_t   r;
    int          p, t, n, hit, k;
    logic [KEY_W-1:0] key;
    if (c.mode) begin
      key_ok   = '{default: 1'b0};
      vert_cnt = 0;
      return;
    end
    p = int'(c.pos) - 1;
    t = int'(c.tex) - 1;
    n = int'(c.nrm) - 1;
    r = '0;
    r.err = ERR_NONE;
    if (p < 0) r.err = ERR_POS_UNDER;
    else if (n < 0) r.err = ERR_NRM_UNDER;
    else if (t < 0) r.err = ERR_TEX_UNDER;
    else if (p >= int'(pos_lim) || p >= (1 << REF_BITS)) r.err = ERR_POS_OVER;
    else if (n >= int'(nrm_lim) || n >= (1 << REF_BITS)) r.err = ERR_NRM_OVER;
    else if (t >= int'(tex_lim) || t >= (1 << REF_BITS)) r.err = ERR_TEX_OVER;
    if (r.err == ERR_NONE) begin
      key = {n[IDX_W-1:0], t[IDX_W-1:0], p[IDX_W-1:0]};
      hit = -1;
      k   = 0;
      while (!dedup_off && hit < 0 && k < int'(vert_cnt)) begin
        if (key_ok[k] && key_mem[k] == key) hit = k;
        k++;
      end
      if (hit >= 0 || vert_cnt < MAX_MESH_VERTS) begin
        r.position_index = p[IDX_W-1:0];
        r.texcoord_index = t[IDX_W-1:0];
        r.normal_index   = n[IDX_W-1:0];
      end
      if (hit >= 0) begin
        r.mesh_index = hit[MESH_W-1:0];
      end else if (vert_cnt >= MAX_MESH_VERTS) begin
        r.err = ERR_TABLE_FULL;
      end else begin
        r.mesh_index = vert_cnt[MESH_W-1:0];
        r.is_new     = 1'b1;
        key_ok[vert_cnt] = !dedup_off;
        if (!dedup_off) key_mem[vert_cnt] = key;
        vert_cnt++;
      end
    end
    mesh_refs_due = {mesh_refs_due, r};
  endtask

  // Append one transaction to the driver's queue
  task automatic feed_item(input corner_t c);
    corner_feed = {corner_feed, c};
    n_queued++;
  endtask

  function automatic corner_t corner(input int p, input int t, input int n);
    corner_t c;
    c.mode = 1'b0;
    c.pos  = p[REF_W-1:0];
    c.tex  = t[REF_W-1:0];
    c.nrm  = n[REF_W-1:0];
    return c;
  endfunction

  // Group start with junk in the ignored fields
  function automatic corner_t group_start();
    corner_t c;
    c      = corner($urandom(), $urandom(), $urandom());
    c.mode = 1'b1;
    return c;
  endfunction

  function automatic logic signed [REF_W-1:0] draw_ref(input bit [CNT_W-1:0] bound,
                                                       input int comp);
    if (bound == 0) return REF_W'($urandom_range(1, 3));
    if (bound <= 64) return REF_W'($urandom_range(1, bound));
    return ref_pool[comp][$urandom_range(0, 7)];
  endfunction

  function automatic logic signed [REF_W-1:0] brink_ref(input bit [CNT_W-1:0] bound);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return -21'sd1;
      2:       return bound;
      3:       return REF_W'(bound + 1);
      4:       return -21'sd1048576;
      default: return 21'sd1048575;
    endcase
  endfunction

  // Mostly well-formed corners, with group starts, noise and boundary refs
  function automatic corner_t random_item();
    corner_t c;
    int      sel;
    c   = corner(draw_ref(pos_lim, 0), draw_ref(tex_lim, 1), draw_ref(nrm_lim, 2));
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      c = group_start();
    end else if (sel < 14) begin
      c = corner($urandom(), $urandom(), $urandom());
    end else if (sel < 22) begin
      case ($urandom_range(0, 2))
        0:       c.pos = brink_ref(pos_lim);
        1:       c.tex = brink_ref(tex_lim);
        default: c.nrm = brink_ref(nrm_lim);
      endcase
    end
    return c;
  endfunction

  function automatic void fill_pools();
    int lim;
    for (int comp = 0; comp < 3; comp++) begin
      lim = (comp == 0) ? pos_lim : (comp == 1) ? tex_lim : nrm_lim;
      if (lim > 1048575) lim = 1048575;
      if (lim < 1) lim = 1;
      for (int k = 0; k < 8; k++) ref_pool[comp][k] = REF_W'($urandom_range(1, lim));
      ref_pool[comp][0] = REF_W'(1);
      ref_pool[comp][1] = REF_W'(lim);
    end
  endfunction

  task automatic set_reg(input cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val[CNT_W-1:0];
    case (idx)
      CFG_POSITION_COUNT: pos_lim   = val[CNT_W-1:0];
      CFG_NORMAL_COUNT:   nrm_lim   = val[CNT_W-1:0];
      CFG_TEXCOORD_COUNT: tex_lim   = val[CNT_W-1:0];
      CFG_DEDUP_DISABLE:  dedup_off = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every transaction is in and every result is out, then let a
  // trailing group start finish
  task automatic drain(input int tail);
    do @(posedge clk);
    while (n_accepted != n_queued || mesh_refs_due.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_limits(input int unsigned pc, input int unsigned nc,
                            input int unsigned tc, input bit off);
    set_reg(CFG_POSITION_COUNT, pc);
    set_reg(CFG_NORMAL_COUNT, nc);
    set_reg(CFG_TEXCOORD_COUNT, tc);
    set_reg(CFG_DEDUP_DISABLE, off);
  endtask

  task automatic random_phase(input int unsigned pc, input int unsigned nc,
                              input int unsigned tc, input bit off, input int count);
    drain(10);
    set_limits(pc, nc, tc, off);
    fill_pools();
    feed_item(group_start());
    repeat (count) feed_item(random_item());
  endtask

  // Input driver: hold the transaction until accepted, advance on handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        dedup_corner(cur_corner);
        n_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_chan.valid <= 1'b0;
        end else if (corner_feed.size() != 0 && (calm || $urandom_range(0, 4) != 0)) begin
          cur_corner = corner_feed.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.mode         <= cur_corner.mode;
          in_chan.position_ref <= cur_corner.pos;
          in_chan.texcoord_ref <= cur_corner.tex;
          in_chan.normal_ref   <= cur_corner.nrm;
        end else begin
          if (corner_feed.size() != 0) feed_gap = $urandom_range(0, 3);
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random bursts of back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap--;
      out_chan.ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      drain_gap    = 300;
      out_chan.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      drain_gap = $urandom_range(0, 3);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    vert_ref_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_results++;
      if (mesh_refs_due.size() == 0) begin
        $error("result transaction with no corner pending");
        fails++;
      end else begin
        e = mesh_refs_due.pop_front();
        if (out_chan.mesh_index !== e.mesh_index) begin
          $error("mesh_index: expected %0d, got %0d", e.mesh_index, out_chan.mesh_index);
          fails++;
        end
        if (out_chan.is_new !== e.is_new) begin
          $error("is_new: expected %0d, got %0d", e.is_new, out_chan.is_new);
          fails++;
        end
        if (out_chan.position_index !== e.position_index) begin
          $error("position_index: expected %0d, got %0d", e.position_index,
                 out_chan.position_index);
          fails++;
        end
        if (out_chan.texcoord_index !== e.texcoord_index) begin
          $error("texcoord_index: expected %0d, got %0d", e.texcoord_index,
                 out_chan.texcoord_index);
          fails++;
        end
        if (out_chan.normal_index !== e.normal_index) begin
          $error("normal_index: expected %0d, got %0d", e.normal_index,
                 out_chan.normal_index);
          fails++;
        end
        if (out_chan.error_code !== e.err) begin
          $error("error_code: expected %0d, got %0d", e.err, out_chan.error_code);
          fails++;
        end
        if (e.err == ERR_TABLE_FULL) n_full++;
        if (e.err != ERR_NONE) n_err++;
        else if (e.is_new) n_new++;
        else n_hits++;
      end
    end
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = '0;
    cfg_wr_data          = '0;
    in_chan.valid        = 1'b0;
    in_chan.mode         = 1'b0;
    in_chan.position_ref = '0;
    in_chan.texcoord_ref = '0;
    in_chan.normal_ref   = '0;
    out_chan.ready       = 1'b0;
    key_ok               = '{default: 1'b0};
    vert_cnt             = 0;
    {pos_lim, nrm_lim, tex_lim, dedup_off} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset counts: every corner overflows, one bound opened at a time
    feed_item(corner(1, 1, 1));
    drain(10);
    set_reg(CFG_POSITION_COUNT, 8);
    feed_item(corner(1, 1, 1));
    drain(10);
    set_reg(CFG_NORMAL_COUNT, 6);
    feed_item(corner(1, 1, 1));
    drain(10);
    set_reg(CFG_TEXCOORD_COUNT, 4);

    // Error priority, hits and misses at the edges of the bounds
    feed_item(group_start());
    feed_item(corner(1, 1, 1));
    feed_item(corner(1, 1, 1));
    feed_item(corner(8, 4, 6));
    feed_item(corner(0, 1, 1));
    feed_item(corner(1, 1, 0));
    feed_item(corner(1, 0, 1));
    feed_item(corner(0, 0, 0));
    feed_item(corner(1, 0, 0));
    feed_item(corner(-1048576, 1, 1));
    feed_item(corner(1048575, 1, 1));
    feed_item(corner(9, 1, 1));
    feed_item(corner(1, 1, 7));
    feed_item(corner(1, 5, 1));
    feed_item(corner(9, 5, 7));
    feed_item(corner(1, 5, 7));
    feed_item(corner(1, 1, -1));
    feed_item(corner(2, 1, 1));
    feed_item(corner(8, 4, 6));
    feed_item(group_start());
    feed_item(corner(1, 1, 1));
    drain(10);
    set_reg(CFG_DEDUP_DISABLE, 1);
    feed_item(corner(1, 1, 1));
    feed_item(corner(1, 1, 1));
    drain(10);
    set_reg(CFG_DEDUP_DISABLE, 0);
    feed_item(corner(1, 1, 1));
    feed_item(corner(2, 2, 2));

    // Random phases; the first one starves the result side for a while
    random_phase(4, 3, 5, 0, 230);
    hold_off_req = 1'b1;
    random_phase(1, 1, 1, 0, 200);
    random_phase(6, 2, 3, 1, 230);
    random_phase(1048576, 1048576, 1048576, 0, 230);
    random_phase(2097151, 1048576, 7, 0, 230);
    random_phase($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(2, 8),
                 $urandom_range(0, 1), 230);
    drain(10);
    calm = 1'b1;
    random_phase(3, 4, 2, 0, 265);
    drain(20);

    $display("Accepted %0d transactions, checked %0d results: %0d new, %0d hits, %0d errors",
             n_accepted, n_results, n_new, n_hits, n_err);
    $display("Table-full results seen: %0d; mismatches: %0d", n_full, fails);
    if (fails == 0 && mesh_refs_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
